// File: rtl/core/prt_pkg.sv
// ============================================================================
// prt_pkg - shared types and constants of the prescaled reload timer
// Register offsets, item codes, the queued command and the result item.
// ============================================================================
package prt_pkg;

    // default width of the timer registers
    localparam int REG_WIDTH_DEF = 32;

    // bus and tick fields have fixed widths
    localparam int OFS_W  = 10;
    localparam int DATA_W = 32;
    // tick cycles plus the kept remainder fit in one more bit
    localparam int TOT_W  = DATA_W + 1;

    // depth of the command queue between front and back
    localparam int QDEPTH = 2;

    // mode field codes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register byte offsets
    localparam logic [OFS_W-1:0] OFS_CONTROL    = 10'h000;
    localparam logic [OFS_W-1:0] OFS_IRQ_ENABLE = 10'h00C;
    localparam logic [OFS_W-1:0] OFS_STATUS     = 10'h010;
    localparam logic [OFS_W-1:0] OFS_PRESCALE   = 10'h028;
    localparam logic [OFS_W-1:0] OFS_RELOAD     = 10'h02C;
    localparam logic [OFS_W-1:0] OFS_COUNT      = 10'h034;

    // bit positions inside control and status
    localparam int ENABLE_BIT = 0;
    localparam int UPDATE_BIT = 0;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNALIGNED = 2'd1,
        STAT_FAULT     = 2'd2
    } stat_t;

    // classified operation of one item
    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_TICK,
        OP_NONE,
        OP_UNALIGNED,
        OP_FAULT
    } op_t;

    // decoded register select
    typedef enum logic [2:0] {
        SEL_CONTROL,
        SEL_IRQ_ENABLE,
        SEL_STATUS,
        SEL_PRESCALE,
        SEL_RELOAD,
        SEL_COUNT
    } sel_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PRESCALE,
        BK_RELOAD
    } bk_state_t;

    // command handed from front to back; arg is write data or tick cycles
    typedef struct packed {
        op_t               op;
        sel_t              sel;
        logic [DATA_W-1:0] arg;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        stat_t             status;
        logic [DATA_W-1:0] count_now;
        logic              update_pending;
    } res_t;

endpackage

// File: rtl/core/prt_front.sv
// ============================================================================
// prt_front - item decode and command queue
// Classifies each item into an operation and register select, and holds
// the commands in a short queue until the back end takes them.
// ============================================================================
module prt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    mode,
    input  logic [prt_pkg::OFS_W-1:0]     reg_offset,
    input  logic [prt_pkg::DATA_W-1:0]    write_data,
    input  logic                          word_access,
    input  logic [prt_pkg::DATA_W-1:0]    tick_cycles,
    output logic                          cmd_valid,
    input  logic                          cmd_pop,
    output prt_pkg::cmd_t                 cmd
);

    localparam int PW = (prt_pkg::QDEPTH > 1) ? $clog2(prt_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(prt_pkg::QDEPTH + 1);

    prt_pkg::cmd_t  q_mem [prt_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  fill_reg, fill_next;
    prt_pkg::cmd_t  cmd_in;
    prt_pkg::sel_t  sel_dec;
    logic           sel_hit;
    logic           do_push;
    logic           do_pop;

    // offset decode
    always_comb
    begin
        sel_hit = 1'b1;
        sel_dec = prt_pkg::SEL_CONTROL;
        unique case (reg_offset)
            prt_pkg::OFS_CONTROL:    sel_dec = prt_pkg::SEL_CONTROL;
            prt_pkg::OFS_IRQ_ENABLE: sel_dec = prt_pkg::SEL_IRQ_ENABLE;
            prt_pkg::OFS_STATUS:     sel_dec = prt_pkg::SEL_STATUS;
            prt_pkg::OFS_PRESCALE:   sel_dec = prt_pkg::SEL_PRESCALE;
            prt_pkg::OFS_RELOAD:     sel_dec = prt_pkg::SEL_RELOAD;
            prt_pkg::OFS_COUNT:      sel_dec = prt_pkg::SEL_COUNT;
            default:                 sel_hit = 1'b0;
        endcase
    end

    // classify the item; the width check comes before the offset
    always_comb
    begin
        cmd_in.sel = sel_dec;
        cmd_in.arg = write_data;
        priority if (mode == prt_pkg::MODE_READ || mode == prt_pkg::MODE_WRITE)
        begin
            if (!word_access)
                cmd_in.op = prt_pkg::OP_UNALIGNED;
            else if (!sel_hit)
                cmd_in.op = prt_pkg::OP_FAULT;
            else if (mode == prt_pkg::MODE_READ)
                cmd_in.op = prt_pkg::OP_READ;
            else
                cmd_in.op = prt_pkg::OP_WRITE;
        end
        else if (mode == prt_pkg::MODE_TICK)
        begin
            cmd_in.op  = prt_pkg::OP_TICK;
            cmd_in.arg = tick_cycles;
        end
        else
        begin
            cmd_in.op = prt_pkg::OP_NONE;
        end
    end

    // queue pointers and fill level
    assign full      = (fill_reg == CW'(prt_pkg::QDEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(prt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(prt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

// File: rtl/core/prt_divider.sv
// ============================================================================
// prt_divider - iterative restoring divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ============================================================================
module prt_divider #(
    parameter int DIVW = prt_pkg::REG_WIDTH_DEF + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [prt_pkg::TOT_W-1:0]   dividend,
    input  logic [DIVW-1:0]             divisor,
    output logic                        busy,
    output logic                        done,
    output logic [prt_pkg::TOT_W-1:0]   quotient,
    output logic [DIVW-1:0]             remainder
);

    localparam int NUMW = prt_pkg::TOT_W;
    localparam int RW   = DIVW + 1;
    localparam int CW   = $clog2(NUMW + 1);

    logic [NUMW-1:0] dq_reg, dq_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [DIVW-1:0] div_reg, div_next;
    logic [CW-1:0]   step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW-1:0]   trial;
    logic            fits;

    // one restoring step
    assign trial = {rem_reg[RW-2:0], dq_reg[NUMW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (trial - {1'b0, div_reg}) : trial;
            dq_next   = {dq_reg[NUMW-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == CW'(NUMW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg[DIVW-1:0];

endmodule

// File: rtl/core/prt_back.sv
// ============================================================================
// prt_back - register file and tick sequencer
// Carries out queued commands, runs the prescale divide and the reload
// modulo on the shared divider, and holds the result item.
// ============================================================================
module prt_back #(
    parameter int REGISTER_WIDTH = prt_pkg::REG_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  prt_pkg::cmd_t                 cmd,
    output logic                          div_start,
    output logic [prt_pkg::TOT_W-1:0]     div_dividend,
    output logic [REGISTER_WIDTH:0]       div_divisor,
    input  logic                          div_done,
    input  logic [prt_pkg::TOT_W-1:0]     div_quot,
    input  logic [REGISTER_WIDTH:0]       div_rem,
    output logic                          res_valid,
    input  logic                          res_pop,
    output prt_pkg::res_t                 res
);

    localparam int W = REGISTER_WIDTH;

    prt_pkg::bk_state_t state_reg, state_next;
    logic [W-1:0] ctrl_reg, ctrl_next;
    logic [W-1:0] irqen_reg, irqen_next;
    logic [W-1:0] stat_reg, stat_next;
    logic [W-1:0] psc_reg, psc_next;
    logic [W-1:0] arr_reg, arr_next;
    logic [W-1:0] cnt_reg, cnt_next;
    logic [W-1:0] rem_reg, rem_next;
    logic         res_valid_reg, res_valid_next;
    prt_pkg::res_t res_reg, res_next;

    logic                      slot_free;
    logic                      accept;
    logic                      tick_run;
    logic [W-1:0]              cnt_sum;
    logic                      wrap_hit;
    logic [prt_pkg::DATA_W-1:0] rd_val;
    logic                      finish;
    logic [prt_pkg::DATA_W-1:0] fin_data;
    prt_pkg::stat_t            fin_stat;

    // shared decisions
    assign slot_free = !res_valid_reg || res_pop;
    assign accept    = (state_reg == prt_pkg::BK_IDLE) && cmd_valid && slot_free;
    assign tick_run  = (cmd.op == prt_pkg::OP_TICK) && ctrl_reg[prt_pkg::ENABLE_BIT];
    assign cnt_sum   = cnt_reg + div_quot[W-1:0];
    assign wrap_hit  = (arr_reg != '0) && (cnt_sum >= arr_reg);

    // register read mux
    always_comb
    begin
        rd_val = '0;
        unique case (cmd.sel)
            prt_pkg::SEL_CONTROL:    rd_val = prt_pkg::DATA_W'(ctrl_reg);
            prt_pkg::SEL_IRQ_ENABLE: rd_val = prt_pkg::DATA_W'(irqen_reg);
            prt_pkg::SEL_STATUS:     rd_val = prt_pkg::DATA_W'(stat_reg);
            prt_pkg::SEL_PRESCALE:   rd_val = prt_pkg::DATA_W'(psc_reg);
            prt_pkg::SEL_RELOAD:     rd_val = prt_pkg::DATA_W'(arr_reg);
            prt_pkg::SEL_COUNT:      rd_val = prt_pkg::DATA_W'(cnt_reg);
            default:                 rd_val = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prt_pkg::BK_IDLE:
            begin
                if (accept && tick_run)
                    state_next = prt_pkg::BK_PRESCALE;
            end
            prt_pkg::BK_PRESCALE:
            begin
                if (div_done)
                    state_next = wrap_hit ? prt_pkg::BK_RELOAD : prt_pkg::BK_IDLE;
            end
            prt_pkg::BK_RELOAD:
            begin
                if (div_done)
                    state_next = prt_pkg::BK_IDLE;
            end
            default: state_next = prt_pkg::BK_IDLE;
        endcase
    end

    // register updates, divider control and result
    always_comb
    begin
        ctrl_next      = ctrl_reg;
        irqen_next     = irqen_reg;
        stat_next      = stat_reg;
        psc_next       = psc_reg;
        arr_next       = arr_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        div_start      = 1'b0;
        div_dividend   = prt_pkg::TOT_W'(cmd.arg) + prt_pkg::TOT_W'(rem_reg);
        div_divisor    = (W+1)'(psc_reg) + (W+1)'(1);
        finish         = 1'b0;
        fin_data       = '0;
        fin_stat       = prt_pkg::STAT_OK;
        unique case (state_reg)
            prt_pkg::BK_IDLE:
            begin
                if (accept)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        prt_pkg::OP_READ:
                        begin
                            finish   = 1'b1;
                            fin_data = rd_val;
                        end
                        prt_pkg::OP_WRITE:
                        begin
                            finish = 1'b1;
                            unique case (cmd.sel)
                                prt_pkg::SEL_CONTROL:    ctrl_next  = cmd.arg[W-1:0];
                                prt_pkg::SEL_IRQ_ENABLE: irqen_next = cmd.arg[W-1:0];
                                prt_pkg::SEL_STATUS:     stat_next  = cmd.arg[W-1:0];
                                prt_pkg::SEL_PRESCALE:   psc_next   = cmd.arg[W-1:0];
                                prt_pkg::SEL_RELOAD:     arr_next   = cmd.arg[W-1:0];
                                prt_pkg::SEL_COUNT:      cnt_next   = cmd.arg[W-1:0];
                                default:                 finish     = 1'b1;
                            endcase
                        end
                        prt_pkg::OP_TICK:
                        begin
                            // disabled tick answers at once
                            if (tick_run)
                                div_start = 1'b1;
                            else
                                finish = 1'b1;
                        end
                        prt_pkg::OP_UNALIGNED:
                        begin
                            finish   = 1'b1;
                            fin_stat = prt_pkg::STAT_UNALIGNED;
                        end
                        prt_pkg::OP_FAULT:
                        begin
                            finish   = 1'b1;
                            fin_stat = prt_pkg::STAT_FAULT;
                        end
                        default: finish = 1'b1;
                    endcase
                end
            end
            prt_pkg::BK_PRESCALE:
            begin
                div_dividend = prt_pkg::TOT_W'(cnt_sum);
                div_divisor  = (W+1)'(arr_reg);
                if (div_done)
                begin
                    rem_next = div_rem[W-1:0];
                    cnt_next = cnt_sum;
                    if (wrap_hit)
                    begin
                        // counter reached reload: flag and fold back
                        stat_next[prt_pkg::UPDATE_BIT] = 1'b1;
                        div_start = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            prt_pkg::BK_RELOAD:
            begin
                div_dividend = prt_pkg::TOT_W'(cnt_reg);
                div_divisor  = (W+1)'(arr_reg);
                if (div_done)
                begin
                    cnt_next = div_rem[W-1:0];
                    finish   = 1'b1;
                end
            end
            default: finish = 1'b0;
        endcase
        if (finish)
        begin
            res_valid_next          = 1'b1;
            res_next.read_data      = fin_data;
            res_next.status         = fin_stat;
            res_next.count_now      = prt_pkg::DATA_W'(cnt_next);
            res_next.update_pending = stat_next[prt_pkg::UPDATE_BIT];
        end
    end

    // control and timer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prt_pkg::BK_IDLE;
            ctrl_reg      <= '0;
            irqen_reg     <= '0;
            stat_reg      <= '0;
            psc_reg       <= '0;
            arr_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctrl_reg      <= ctrl_next;
            irqen_reg     <= irqen_next;
            stat_reg      <= stat_next;
            psc_reg       <= psc_next;
            arr_reg       <= arr_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/core/prescaled_reload_timer.sv
// ============================================================================
// prescaled_reload_timer - timer with prescaler and auto-reload
// Bus reads and writes of six registers and ticks of elapsed cycles.
//
//   channel   handshake          payload
//   input     push / full        mode, reg_offset, write_data, word_access,
//                                tick_cycles
//   result    empty / pop        read_data, status, count_now, update_pending
//
// A read, write, fault or disabled tick is answered as the back end takes it.
// An enabled tick runs the prescale divide in the shared restoring divider,
// then the reload modulo when the counter wraps. Reset clears the control,
// timer and handshake registers but not the queue, result or divider data.
// A two-entry command queue takes items while the back end is busy; the back
// end holds off when its result register is still waiting to be popped.
// ============================================================================
module prescaled_reload_timer #(
    parameter int REGISTER_WIDTH = prt_pkg::REG_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    mode,
    input  logic [prt_pkg::OFS_W-1:0]     reg_offset,
    input  logic [prt_pkg::DATA_W-1:0]    write_data,
    input  logic                          word_access,
    input  logic [prt_pkg::DATA_W-1:0]    tick_cycles,
    output logic                          empty,
    input  logic                          pop,
    output logic [prt_pkg::DATA_W-1:0]    read_data,
    output logic [1:0]                    status,
    output logic [prt_pkg::DATA_W-1:0]    count_now,
    output logic                          update_pending
);

    logic                          cmd_valid;
    logic                          cmd_pop;
    prt_pkg::cmd_t                 cmd;
    logic                          div_start;
    logic [prt_pkg::TOT_W-1:0]     div_dividend;
    logic [REGISTER_WIDTH:0]       div_divisor;
    logic                          div_busy;
    logic                          div_done;
    logic [prt_pkg::TOT_W-1:0]     div_quot;
    logic [REGISTER_WIDTH:0]       div_rem;
    logic                          res_valid;
    prt_pkg::res_t                 res;

    // front: decode and queue
    prt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .reg_offset  (reg_offset),
        .write_data  (write_data),
        .word_access (word_access),
        .tick_cycles (tick_cycles),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd)
    );

    // back: registers and sequencer
    prt_back #(
        .REGISTER_WIDTH (REGISTER_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .div_rem      (div_rem),
        .res_valid    (res_valid),
        .res_pop      (pop),
        .res          (res)
    );

    // shared divider
    prt_divider #(
        .DIVW (REGISTER_WIDTH + 1)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // result ports
    assign empty          = !res_valid;
    assign read_data      = res.read_data;
    assign status         = res.status;
    assign count_now      = res.count_now;
    assign update_pending = res.update_pending;

    // back end never takes from an empty queue
    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from empty queue");

    // divider is never restarted mid-run
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a divide started is still running on the next cycle
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy && !div_done)
        else $error("divider did not start");

endmodule
